[src/tvu_pkg.sv]
// ----------------------------------------------------------------------------
// tvu_pkg: shared types and constants of the Telex to UTF-8 converter
// Key numbering and the result burst that travels from the key lookup
// to the output serializer.
// ----------------------------------------------------------------------------
package tvu_pkg;

  // Number of Telex keys in the table; key codes run from 1 to NUM_KEYS.
  localparam int NUM_KEYS = 74;

  // Key code that means no key is pending.
  localparam logic [6:0] KEY_NONE = 7'd0;

  // Most result bytes one input byte can cause.
  localparam int MAX_BYTES = 4;

  // Result bytes of one input transaction, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [2:0]                count;
  } tvu_burst_t;

endpackage

[src/tvu_lookup.sv]
// ----------------------------------------------------------------------------
// tvu_lookup: Telex key lookup and UTF-8 encoding
// Given the pending key and one input byte, computes the next pending key
// and the burst of UTF-8 bytes that the byte causes.
// ----------------------------------------------------------------------------
module tvu_lookup
  import tvu_pkg::*;
(
  input  logic [6:0]  key_i,
  input  logic [7:0]  char_i,
  input  logic        end_i,
  output logic [6:0]  key_o,
  output tvu_burst_t  burst_o
);

  // Characters that take part in keys.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Y     = 8'h79;

  // Base keys; the five tone marks of each vowel base follow it in the numbering.
  localparam logic [6:0] K_A  = 7'd1;
  localparam logic [6:0] K_E  = 7'd7;
  localparam logic [6:0] K_O  = 7'd13;
  localparam logic [6:0] K_U  = 7'd19;
  localparam logic [6:0] K_I  = 7'd25;
  localparam logic [6:0] K_Y  = 7'd31;
  localparam logic [6:0] K_OO = 7'd37;
  localparam logic [6:0] K_AA = 7'd43;
  localparam logic [6:0] K_OW = 7'd49;
  localparam logic [6:0] K_AW = 7'd55;
  localparam logic [6:0] K_UW = 7'd61;
  localparam logic [6:0] K_EE = 7'd67;
  localparam logic [6:0] K_D  = 7'd73;
  localparam logic [6:0] K_DD = 7'd74;

  // Code point of each key, key 1 first.
  localparam logic [15:0] KEY_CP [NUM_KEYS] = '{
    16'h0061, 16'h00E1, 16'h00E0, 16'h1EA3, 16'h00E3, 16'h1EA1,
    16'h0065, 16'h00E9, 16'h00E8, 16'h1EBB, 16'h1EBD, 16'h1EB9,
    16'h006F, 16'h00F3, 16'h00F2, 16'h1ECF, 16'h00F5, 16'h1ECD,
    16'h0075, 16'h00FA, 16'h00F9, 16'h1EE7, 16'h0169, 16'h1EE5,
    16'h0069, 16'h00ED, 16'h00EC, 16'h1EC9, 16'h0129, 16'h1ECB,
    16'h0079, 16'h00FD, 16'h1EF3, 16'h1EF7, 16'h1EF9, 16'h1EF5,
    16'h00F4, 16'h1ED1, 16'h1ED3, 16'h1ED5, 16'h1ED7, 16'h1ED9,
    16'h00E2, 16'h1EA5, 16'h1EA7, 16'h1EA9, 16'h1EAB, 16'h1EAD,
    16'h01A1, 16'h1EDB, 16'h1EDD, 16'h1EDF, 16'h1EE1, 16'h1EE3,
    16'h0103, 16'h1EAF, 16'h1EB1, 16'h1EB3, 16'h1EB5, 16'h1EB7,
    16'h01B0, 16'h1EE9, 16'h1EEB, 16'h1EED, 16'h1EEF, 16'h1EF1,
    16'h00EA, 16'h1EBF, 16'h1EC1, 16'h1EC3, 16'h1EC5, 16'h1EC7,
    16'h0064, 16'h0111
  };

  // UTF-8 bytes of one key, first byte in slot 0.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [1:0]      len;
  } utf8_t;

  // Offset of a tone mark letter within a key group, zero for other bytes.
  function automatic logic [2:0] tone_ofs(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    unique case (c)
      CH_S:    r = 3'd1;
      CH_F:    r = 3'd2;
      CH_R:    r = 3'd3;
      CH_X:    r = 3'd4;
      CH_J:    r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Key that the pending key grows into with one more byte, or none.
  function automatic logic [6:0] ext_key(input logic [6:0] k, input logic [7:0] c);
    logic [6:0] r;
    logic [2:0] t;
    r = KEY_NONE;
    t = tone_ofs(c);
    unique case (k)
      K_A: begin
        if (c == CH_A) r = K_AA;
        else if (c == CH_W) r = K_AW;
        else if (t != 3'd0) r = k + {4'd0, t};
      end
      K_E: begin
        if (c == CH_E) r = K_EE;
        else if (t != 3'd0) r = k + {4'd0, t};
      end
      K_O: begin
        if (c == CH_O) r = K_OO;
        else if (c == CH_W) r = K_OW;
        else if (t != 3'd0) r = k + {4'd0, t};
      end
      K_U: begin
        if (c == CH_W) r = K_UW;
        else if (t != 3'd0) r = k + {4'd0, t};
      end
      K_I, K_Y, K_OO, K_AA, K_OW, K_AW, K_UW, K_EE: begin
        if (t != 3'd0) r = k + {4'd0, t};
      end
      K_D: begin
        if (c == CH_D) r = K_DD;
      end
      default: r = KEY_NONE;
    endcase
    return r;
  endfunction

  // Key that a single byte starts, or none.
  function automatic logic [6:0] start_key(input logic [7:0] c);
    logic [6:0] r;
    r = KEY_NONE;
    unique case (c)
      CH_A:    r = K_A;
      CH_E:    r = K_E;
      CH_O:    r = K_O;
      CH_U:    r = K_U;
      CH_I:    r = K_I;
      CH_Y:    r = K_Y;
      CH_D:    r = K_D;
      default: r = KEY_NONE;
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a key; no key gives zero bytes.
  function automatic utf8_t encode(input logic [6:0] k);
    utf8_t      r;
    logic [15:0] cp;
    r.b   = '0;
    r.len = 2'd0;
    if (k != KEY_NONE) begin
      cp = KEY_CP[k - 7'd1];
      if (cp < 16'h0080) begin
        r.b[0] = cp[7:0];
        r.len  = 2'd1;
      end else if (cp < 16'h0800) begin
        r.b[0] = {3'b110, cp[10:6]};
        r.b[1] = {2'b10, cp[5:0]};
        r.len  = 2'd2;
      end else begin
        r.b[0] = {4'b1110, cp[15:12]};
        r.b[1] = {2'b10, cp[11:6]};
        r.b[2] = {2'b10, cp[5:0]};
        r.len  = 2'd3;
      end
    end
    return r;
  endfunction

  logic [6:0] key_valid;
  logic [6:0] key_ext;
  logic [6:0] key_start;
  logic [6:0] key_mid;
  logic       is_space;
  logic       flush_a;
  logic       put_char;
  utf8_t      enc_a;
  utf8_t      enc_b;
  logic [2:0] mid_end;

  // A key code outside the table counts as no key.
  assign key_valid = (key_i <= 7'(NUM_KEYS)) ? key_i : KEY_NONE;

  assign is_space  = (char_i == CH_SPACE);
  assign key_ext   = is_space ? KEY_NONE : ext_key(key_valid, char_i);
  assign key_start = start_key(char_i);

  // The pending key is flushed unless the byte grows it.
  assign flush_a  = is_space || (key_ext == KEY_NONE);
  assign put_char = is_space || ((key_ext == KEY_NONE) && (key_start == KEY_NONE));

  // Pending key after the byte itself, before the end flag.
  always_comb begin
    if (is_space) begin
      key_mid = KEY_NONE;
    end else if (key_ext != KEY_NONE) begin
      key_mid = key_ext;
    end else begin
      key_mid = key_start;
    end
  end

  assign enc_a = encode(flush_a ? key_valid : KEY_NONE);
  assign enc_b = encode(end_i ? key_mid : KEY_NONE);
  assign key_o = end_i ? KEY_NONE : key_mid;

  // Burst: flushed key, then the passed byte, then the key flushed at the end.
  assign mid_end = {1'b0, enc_a.len} + {2'b00, put_char};

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (3'(i) < {1'b0, enc_a.len}) begin
        burst_o.data[i] = enc_a.b[i];
      end else if (3'(i) < mid_end) begin
        burst_o.data[i] = char_i;
      end else begin
        burst_o.data[i] = enc_b.b[2'(3'(i) - mid_end)];
      end
    end
    burst_o.count = mid_end + {1'b0, enc_b.len};
  end

endmodule

[src/tvu_serializer.sv]
// ----------------------------------------------------------------------------
// tvu_serializer: result burst register and byte serializer
// Holds the bytes caused by one input transaction and sends them one per
// transaction on the output stream, marking the last one.
// ----------------------------------------------------------------------------
module tvu_serializer
  import tvu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  tvu_burst_t  burst_i,
  output logic        free_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o    // last_of_run
);

  logic [MAX_BYTES-1:0][7:0] data_q;
  logic [2:0]                count_q, count_d;
  logic [1:0]                pos_q, pos_d;
  logic                      last;
  logic                      take;

  assign m_axis_tvalid_o = (count_q != 3'd0);
  assign last            = ({1'b0, pos_q} + 3'd1) == count_q;
  assign take            = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = data_q[pos_q];
  assign m_axis_tlast_o  = last;

  // A new burst may enter when the register is empty or its last byte leaves.
  assign free_o = !m_axis_tvalid_o || (take && last);

  // Byte position and count of the held burst.
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (load_i) begin
      count_d = burst_i.count;
      pos_d   = 2'd0;
    end else if (take) begin
      if (last) begin
        count_d = 3'd0;
        pos_d   = 2'd0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      pos_q   <= 2'd0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // Burst bytes need no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= burst_i.data;
    end
  end

`ifndef SYNTHESIS
  // The read position always lies inside the held burst.
  a_pos_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({1'b0, pos_q} < count_q))
    else $error("serializer position beyond burst");

  // A burst never holds more bytes than one transaction can cause.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(MAX_BYTES))
    else $error("serializer burst too long");

  // A burst is loaded only when the previous one is gone or leaving.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("burst loaded over pending bytes");

  // A byte that is not taken stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(pos_q)))
    else $error("stalled output byte moved");
`endif

endmodule

[src/telex_to_utf8_vietnamese.sv]
// ----------------------------------------------------------------------------
// telex_to_utf8_vietnamese: Telex to UTF-8 converter for Vietnamese text
// Top level: pending key register, key lookup and output serializer.
// ----------------------------------------------------------------------------
// The block reads Telex text one byte per input transaction and writes the
// UTF-8 text one byte per output transaction. It holds one pending key
// (such as a, aa, aas, ow or dd); a byte that extends it to another key is
// absorbed, otherwise the key leaves as 1 to 3 UTF-8 bytes and the byte
// starts a new key or passes through unchanged. A space flushes the key and
// passes, and tlast on input flushes the key after its byte. tlast on output
// marks the final byte caused by one input byte. An input byte that causes
// no output leaves the block free for the next input byte; one that causes n
// bytes (at most four) holds the output register until all n have left, at
// one byte per cycle while the output is not stalled, and the next input
// byte is taken in the cycle the last one leaves.
// ----------------------------------------------------------------------------
module telex_to_utf8_vietnamese
  import tvu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code[7:0]
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic        m_axis_tlast_o    // last_of_run
);

  logic [6:0] key_q, key_d;
  tvu_burst_t burst;
  logic       free;
  logic       accept;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  // Next key and result bytes of the offered byte.
  tvu_lookup u_lookup (
    .key_i   (key_q),
    .char_i  (s_axis_tdata_i),
    .end_i   (s_axis_tlast_i),
    .key_o   (key_d),
    .burst_o (burst)
  );

  // Pending key advances with each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_NONE;
    end else if (accept) begin
      key_q <= key_d;
    end
  end

  // Result bytes leave one per output transaction.
  tvu_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .burst_i         (burst),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // The pending key is always a table entry or none.
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q <= 7'(NUM_KEYS))
    else $error("pending key outside table");

  // A transaction flagged as end of text leaves no key pending.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast_i) |=> (key_q == KEY_NONE))
    else $error("key pending after end of text");

  // The input is held off only while result bytes are waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no pending output");
`endif

endmodule
